// File: rtl/core/ckt_pkg.sv
// Package for the counted key table: sizes, command and status codes,
// controller-to-datapath command word. No dependencies.
package ckt_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W     = 64;
  localparam int AMT_W     = 16;
  localparam int OUT_CNT_W = 16;
  localparam int OUT_USE_W = 5;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W    = $clog2(ENTRIES + 1);
  localparam int SUM_W     = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic exec;
  } ckt_cmd_t;

endpackage

// File: rtl/core/ckt_ctrl.sv
// Controller for the counted key table: sequences capture, match and execute
// and owns the output valid flag. Depends on ckt_pkg.
module ckt_ctrl
  import ckt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ckt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;
  logic   accept;

  assign out_load  = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || out_load;
  assign accept    = in_tvalid && in_tready;

  assign cmd.capture = accept;
  assign cmd.match   = (state_r == S_MATCH);
  assign cmd.exec    = out_load;

  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_load) state_nxt = accept ? S_MATCH : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/ckt_datapath.sv
// Datapath for the counted key table: key and count stores, parallel match,
// count update, compaction and output word register. Depends on ckt_pkg.
module ckt_datapath
  import ckt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ckt_cmd_t             cmd,
  input  logic [1:0]           in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [AMT_W-1:0]     in_amount,
  output logic [1:0]           out_status,
  output logic [OUT_CNT_W-1:0] out_count_now,
  output logic [OUT_USE_W-1:0] out_entries_used
);

  // bytes from the first zero byte on are cleared
  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             alive;
    r     = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (k[8*b +: 8] == 8'h00) alive = 1'b0;
      if (alive) r[8*b +: 8] = k[8*b +: 8];
    end
    return r;
  endfunction

  logic [KEY_W-1:0]      key_store_r   [ENTRIES];
  logic [KEY_W-1:0]      key_store_nxt [ENTRIES];
  logic [COUNT_BITS-1:0] count_store_r   [ENTRIES];
  logic [COUNT_BITS-1:0] count_store_nxt [ENTRIES];
  logic [USED_W-1:0]     used_r, used_nxt;

  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [AMT_W-1:0] amt_r;
  logic [ENTRIES-1:0] match_r;

  status_t               status_r;
  logic [OUT_CNT_W-1:0]  count_now_r;
  logic [OUT_USE_W-1:0]  used_out_r;

  logic [IDX_W-1:0]      idx;
  logic                  hit;
  logic                  full;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [SUM_W-1:0]      cnt_w, amt_w, sum_w, max_w, diff_w;
  logic [COUNT_BITS-1:0] sum_sat, amt_sat;
  logic                  drop;
  status_t               status_c;
  logic [COUNT_BITS-1:0] cnt_res;

  // keys are unique in the table, so at most one match bit is set
  always_comb begin
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) idx = idx | IDX_W'(i);
    end
  end

  assign hit     = |match_r;
  assign full    = (used_r == USED_W'(ENTRIES));
  assign cnt_sel = count_store_r[idx];
  assign cnt_w   = SUM_W'(cnt_sel);
  assign amt_w   = SUM_W'(amt_r);
  assign max_w   = SUM_W'(CNT_MAX);
  assign sum_w   = cnt_w + amt_w;
  assign diff_w  = cnt_w - amt_w;
  assign sum_sat = (sum_w > max_w) ? CNT_MAX : COUNT_BITS'(sum_w);
  assign amt_sat = (amt_w > max_w) ? CNT_MAX : COUNT_BITS'(amt_w);
  assign drop    = (cmd_r == CMD_REMOVE) && hit && (amt_w >= cnt_w);

  always_comb begin
    key_store_nxt   = key_store_r;
    count_store_nxt = count_store_r;
    used_nxt        = used_r;
    status_c        = ST_DONE;
    cnt_res         = '0;
    unique case (cmd_r)
      CMD_ADD: begin
        priority if (hit) begin
          count_store_nxt[idx] = sum_sat;
          cnt_res              = sum_sat;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          key_store_nxt[used_r[IDX_W-1:0]]   = key_r;
          count_store_nxt[used_r[IDX_W-1:0]] = amt_sat;
          used_nxt                           = used_r + USED_W'(1);
          cnt_res                            = amt_sat;
        end
      end
      CMD_REMOVE: begin
        priority if (!hit) begin
          status_c = ST_ABSENT;
        end else if (drop) begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            if (IDX_W'(i) >= idx) begin
              key_store_nxt[i]   = key_store_r[i+1];
              count_store_nxt[i] = count_store_r[i+1];
            end
          end
          used_nxt = used_r - USED_W'(1);
        end else begin
          count_store_nxt[idx] = COUNT_BITS'(diff_w);
          cnt_res              = COUNT_BITS'(diff_w);
        end
      end
      default: begin
        if (hit) cnt_res = cnt_sel;
        else     status_c = ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      key_r <= canon_key(in_key);
      amt_r <= in_amount;
    end
    if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i] <= (USED_W'(i) < used_r) && (key_store_r[i] == key_r);
      end
    end
    if (cmd.exec) begin
      key_store_r   <= key_store_nxt;
      count_store_r <= count_store_nxt;
      status_r      <= status_c;
      count_now_r   <= OUT_CNT_W'(cnt_res);
      used_out_r    <= OUT_USE_W'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.exec) begin
      used_r <= used_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_count_now    = count_now_r;
  assign out_entries_used = used_out_r;

endmodule

// File: rtl/core/counted_key_table.sv
// Counted key table top level: controller plus datapath.
// Depends on ckt_pkg, ckt_ctrl and ckt_datapath.
//
//   channel | dir | tdata (low bit up)                    | tuser
//   in_     | in  | key[63:0], amount[79:64]              | cmd[1:0]
//   out_    | out | count_now[15:0], entries_used[20:16]  | status[1:0]
//
// Each word goes through a match state, comparing the key with every stored
// entry, then an execute state for the count read-modify-write and compaction shift.
// The next word is taken in the execute cycle when the output register is free.
// In the datapath, reset clears only the occupancy count; stores need no clearing pass.
// A stalled output word holds the block in its execute cycle.
module counted_key_table
  import ckt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key[63:0], amount[79:64]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // count_now[15:0], entries_used[20:16], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  ckt_cmd_t             cmd;
  logic [OUT_CNT_W-1:0] count_now;
  logic [OUT_USE_W-1:0] entries_used;

  ckt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ckt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_cmd           (in_tuser),
    .in_key           (in_tdata[63:0]),
    .in_amount        (in_tdata[79:64]),
    .out_status       (out_tuser),
    .out_count_now    (count_now),
    .out_entries_used (entries_used)
  );

  assign out_tdata = {3'b000, entries_used, count_now};

endmodule

// File: rtl/core/ckt_checker.sv
// Port-level checks for the counted key table, bound to the top level.
// Depends on ckt_pkg and counted_key_table.
module ckt_checker
  import ckt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken during match cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (out_tdata[20:16] == OUT_USE_W'(ENTRIES)) && (out_tdata[15:0] == '0))
    else $error("full status without a full table");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ABSENT) |-> (out_tdata[15:0] == '0))
    else $error("absent key reported a nonzero count");

endmodule

bind counted_key_table ckt_checker u_chk (.*);

// File: sim/counted_key_table_tb.sv
// Self-checking testbench for counted_key_table: stream driver, result monitor
// and a scoreboard class that predicts every result word. Depends on ckt_pkg.
module counted_key_table_tb;
  import ckt_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as lookup
  localparam int POOL_N = 24;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 140;

  typedef struct {
    status_t           status;
    logic [OUT_CNT_W-1:0] count_now;
    logic [OUT_USE_W-1:0] used;
  } table_word_t;

  class counted_table_board;
    logic [KEY_W-1:0]      keys [ENTRIES];
    logic [COUNT_BITS-1:0] counts [ENTRIES];
    int used;
    int fails;
    int checked;
    int full_rejects;
    int drops;
    int saturations;
    table_word_t expected_words[$];

    // key ends at its first zero byte
    static function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      bit stop;
      r = '0;
      stop = 0;
      for (int b = 0; b < KEY_W / 8; b++) begin
        if (k[8*b +: 8] == 8'd0) stop = 1;
        if (!stop) r[8*b +: 8] = k[8*b +: 8];
      end
      return r;
    endfunction

    function int slot_of(logic [KEY_W-1:0] k);
      for (int i = 0; i < used; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function int count_of(logic [KEY_W-1:0] raw_key);
      int idx;
      idx = slot_of(trim_key(raw_key));
      return (idx < 0) ? -1 : int'(counts[idx]);
    endfunction

    function void note_word(logic [1:0] cmd, logic [KEY_W-1:0] raw_key,
                            logic [AMT_W-1:0] amt);
      logic [KEY_W-1:0] k;
      logic [SUM_W-1:0] sum;
      int idx;
      table_word_t w;
      k = trim_key(raw_key);
      idx = slot_of(k);
      w.status = ST_DONE;
      w.count_now = '0;
      case (cmd)
        CMD_ADD: begin
          if (idx >= 0) begin
            sum = SUM_W'(counts[idx]) + SUM_W'(amt);
            if (sum > SUM_W'(CNT_MAX)) begin
              sum = SUM_W'(CNT_MAX);
              saturations++;
            end
            counts[idx] = COUNT_BITS'(sum);
            w.count_now = OUT_CNT_W'(counts[idx]);
          end else if (used >= ENTRIES) begin
            w.status = ST_FULL;
            full_rejects++;
          end else begin
            sum = (SUM_W'(amt) > SUM_W'(CNT_MAX)) ? SUM_W'(CNT_MAX) : SUM_W'(amt);
            keys[used] = k;
            counts[used] = COUNT_BITS'(sum);
            w.count_now = OUT_CNT_W'(counts[used]);
            used++;
          end
        end
        CMD_REMOVE: begin
          if (idx < 0) begin
            w.status = ST_ABSENT;
          end else if (SUM_W'(amt) >= SUM_W'(counts[idx])) begin
            for (int i = idx + 1; i < used; i++) begin
              keys[i-1] = keys[i];
              counts[i-1] = counts[i];
            end
            used--;
            drops++;
          end else begin
            counts[idx] = counts[idx] - COUNT_BITS'(amt);
            w.count_now = OUT_CNT_W'(counts[idx]);
          end
        end
        default: begin
          if (idx < 0) w.status = ST_ABSENT;
          else w.count_now = OUT_CNT_W'(counts[idx]);
        end
      endcase
      w.used = OUT_USE_W'(used);
      expected_words.push_back(w);
    endfunction

    function void report(string field, int exp_val, int act_val);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
      fails++;
    endfunction

    function void check_word(logic [1:0] status, logic [OUT_CNT_W-1:0] cnt,
                             logic [OUT_USE_W-1:0] used_now);
      table_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, status %0d count %0d used %0d",
                 $time, status, cnt, used_now);
        fails++;
        return;
      end
      w = expected_words.pop_front();
      checked++;
      if (status !== w.status) report("status", w.status, status);
      if (cnt !== w.count_now) report("count_now", w.count_now, cnt);
      if (used_now !== w.used) report("entries_used", w.used, used_now);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // key[63:0], amount[79:64]
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // count_now[15:0], entries_used[20:16], zero pad
  logic [1:0]  out_tuser;       // status[1:0]

  counted_table_board model = new();
  logic [KEY_W-1:0] key_pool [POOL_N];
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  bit hold_req = 0;
  int sent = 0;
  int rx_wait = 0;
  int rx_hold = 0;

  counted_key_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amt);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {amt, key};
    do @(posedge clk); while (!in_tready);
    model.note_word(cmd, key, amt);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  // scatter random bytes after the terminating zero byte, half the time
  function automatic logic [KEY_W-1:0] add_noise(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] noise;
    bit hit;
    noise = {$urandom, $urandom};
    hit = 0;
    if ($urandom_range(0, 1) == 0) return k;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (hit) k[8*b +: 8] = noise[8*b +: 8];
      else if (k[8*b +: 8] == 8'd0) hit = 1;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 40 && model.used > 0) k = model.keys[$urandom_range(0, model.used - 1)];
    else if (r < 92) k = key_pool[$urandom_range(0, POOL_N - 1)];
    else return {$urandom, $urandom};
    return add_noise(k);
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount(int cur);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return AMT_W'($urandom_range(0, 15));
    if (r < 5 && cur >= 0) return AMT_W'(cur);
    if (r < 6) return 16'hFFFF - AMT_W'($urandom_range(0, 255));
    return AMT_W'($urandom_range(0, 65535));
  endfunction

  // kind 0 fills, 1 mixes, 2 drains
  function automatic logic [1:0] pick_cmd(int kind);
    int r;
    int add_lim;
    int rem_lim;
    r = $urandom_range(0, 99);
    add_lim = (kind == 0) ? 60 : (kind == 1) ? 35 : 15;
    rem_lim = (kind == 0) ? 75 : (kind == 1) ? 70 : 75;
    if (r < add_lim) return CMD_ADD;
    if (r < rem_lim) return CMD_REMOVE;
    if (r < 95) return CMD_LOOKUP;
    return CMD_SPARE;
  endfunction

  // result monitor and ready pattern
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        model.check_word(out_tuser, out_tdata[15:0], out_tdata[20:16]);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (hold_req) begin
        hold_req = 0;
        rx_hold = 150;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    int len;

    for (int p = 0; p < POOL_N; p++) begin
      key_pool[p] = '0;
      len = (p == 0) ? 0 : $urandom_range(1, 8);
      for (int b = 0; b < len; b++) key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    send_word(CMD_LOOKUP, 64'h0000_0000_0000_0041, 16'd7);
    send_word(CMD_REMOVE, 64'h0000_0000_0000_0041, 16'd1);
    send_word(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_word(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
    send_word(CMD_ADD, 64'hDEAD_BEEF_1234_5600, 16'd0);
    send_word(CMD_LOOKUP, 64'h0000_0000_0000_0000, 16'hFFFF);
    send_word(CMD_REMOVE, 64'h5A00_0000_0000_0000, 16'd0);
    send_word(CMD_ADD, 64'h0000_0000_0043_4241, 16'd100);
    send_word(CMD_LOOKUP, 64'h7777_0000_0043_4241, 16'd0);
    send_word(CMD_REMOVE, 64'h0000_0000_0043_4241, 16'd40);
    send_word(CMD_REMOVE, 64'h0012_3400_0043_4241, 16'd1000);
    send_word(CMD_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3);
    for (int i = 0; i < ENTRIES - 1; i++) begin
      send_word(CMD_ADD, 64'(i + 1), AMT_W'(i * 4400));
    end
    send_word(CMD_ADD, 64'h0102_0304_0506_0708, 16'd9);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 6 || ph == 9) wait_drained();
      tx_quiet = (ph % 4 == 1) || (ph == 3);
      rx_quiet = (ph % 4 == 2);
      if (ph == 3) hold_req = 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        cmd = pick_cmd(ph % 3);
        key = pick_key();
        send_word(cmd, key, pick_amount(model.count_of(key)));
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d words, checked %0d results: %0d full-table rejects,",
             sent, model.checked, model.full_rejects);
    $display("  %0d entries dropped by remove, %0d saturating adds.",
             model.drops, model.saturations);
    if (model.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ckt_pkg.sv
rtl/core/ckt_ctrl.sv
rtl/core/ckt_datapath.sv
rtl/core/counted_key_table.sv
rtl/core/ckt_checker.sv
sim/counted_key_table_tb.sv
